// ----- hw/rtl/mm4_pkg.sv -----
// Package for the 4x4 fixed-point matrix multiplier.
// Holds the opcode constants and the pipeline tag type.
// No dependencies.
package mm4_pkg;

  localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_COMPUTE    = 2'd2;

  // Bookkeeping that travels with each operand pair down the pipeline.
  typedef struct packed {
    logic       first;      // k == 0: restart the sum
    logic       last_k;     // k == DIM-1: sum complete after this term
    logic       last_cell;  // final element of the product
    logic [3:0] index;      // row-major position, low four bits
  } tag_t;

endpackage

// ----- hw/rtl/matrix4x4_multiply_top.sv -----
// Top level of the fixed-point matrix multiplier.
// Uses mm4_pkg for opcodes and the pipeline tag type.
//
// Usage:
//   An item is taken on a rising edge with start high and busy low.
//   opcode 0/1 writes element_value into the left/right store at
//   element_index in that same edge; busy stays low, so loads go one per
//   cycle. An index at or beyond DIM*DIM is dropped, as is opcode 3.
//   opcode 2 raises busy and streams DIM*DIM product elements in
//   row-major order, each on the result ports for one cycle with valid
//   high; last marks the final one. Each element is the full-width sum of
//   DIM products, shifted right arithmetically by FRAC_BITS and
//   saturated to ELEM_WIDTH bits (saturated flags clipping).
//   The single multiplier takes one term per cycle from one read port
//   of each store; terms pass through the read, multiply, accumulate
//   and output registers in turn. busy drops after the cycle that
//   shows the last element.
//   Reset clears both stores to zero through per-entry valid bits.
//   The receiver cannot stall: results must be taken as shown.
module matrix4x4_multiply_top #(
  parameter int DIM        = 4,
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  element_index,
  input  logic [31:0] element_value,
  output logic        valid,
  output logic [3:0]  product_index,
  output logic [31:0] product_value,
  output logic        saturated,
  output logic        last
);

  localparam int NCELLS = DIM * DIM;
  localparam int AW     = $clog2(NCELLS);
  localparam int KW     = $clog2(DIM);
  localparam int EW     = ELEM_WIDTH;
  localparam int PW     = 2 * EW;
  localparam int ACCW   = PW + KW + 1;
  localparam logic [KW-1:0] KLAST = KW'(DIM - 1);

  // Stores and their valid bits
  logic [EW-1:0] left_mem  [NCELLS];
  logic [EW-1:0] right_mem [NCELLS];
  logic [NCELLS-1:0] left_vld;
  logic [NCELLS-1:0] right_vld;

  logic accept;
  logic wr_left;
  logic wr_right;
  logic [AW-1:0] wr_addr;

  // Sequencer
  logic          issuing;
  logic [KW-1:0] row;
  logic [KW-1:0] col;
  logic [KW-1:0] k;
  logic [AW-1:0] rd_addr_l;
  logic [AW-1:0] rd_addr_r;
  mm4_pkg::tag_t issue_tag;

  // Read stage
  logic          rd_vld;
  mm4_pkg::tag_t rd_tag;
  logic [EW-1:0] l_q;
  logic [EW-1:0] r_q;
  logic          l_ok;
  logic          r_ok;
  logic signed [EW-1:0] l_op;
  logic signed [EW-1:0] r_op;

  // Multiply stage
  logic                 mul_vld;
  mm4_pkg::tag_t        mul_tag;
  logic signed [PW-1:0] prod;

  // Accumulate stage
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] acc_next;
  logic                   acc_done;
  mm4_pkg::tag_t          acc_tag;

  // Shift and saturate
  logic signed [ACCW-1:0] shifted;
  logic                   ovf;
  logic [EW-1:0]          sat_val;

  assign accept   = start && !busy;
  assign wr_left  = accept && (opcode == mm4_pkg::OP_LOAD_LEFT) &&
                    (int'(element_index) < NCELLS);
  assign wr_right = accept && (opcode == mm4_pkg::OP_LOAD_RIGHT) &&
                    (int'(element_index) < NCELLS);
  assign wr_addr  = AW'(element_index);

  assign rd_addr_l = AW'(int'(row) * DIM + int'(k));
  assign rd_addr_r = AW'(int'(k) * DIM + int'(col));

  always_comb begin
    issue_tag.first     = (k == '0);
    issue_tag.last_k    = (k == KLAST);
    issue_tag.last_cell = (row == KLAST) && (col == KLAST);
    issue_tag.index     = 4'(int'(row) * DIM + int'(col));
  end

  // Memory arrays: write on load, registered read for compute
  always_ff @(posedge clk) begin
    if (wr_left) begin
      left_mem[wr_addr] <= element_value[EW-1:0];
    end
    if (wr_right) begin
      right_mem[wr_addr] <= element_value[EW-1:0];
    end
    l_q  <= left_mem[rd_addr_l];
    r_q  <= right_mem[rd_addr_r];
    l_ok <= left_vld[rd_addr_l];
    r_ok <= right_vld[rd_addr_r];
  end

  // Entries never written since reset read as zero
  assign l_op = l_ok ? l_q : '0;
  assign r_op = r_ok ? r_q : '0;

  assign acc_next = mul_tag.first ? ACCW'(prod) : acc + ACCW'(prod);

  assign shifted = acc >>> FRAC_BITS;
  assign ovf     = !((&shifted[ACCW-1:EW-1]) || !(|shifted[ACCW-1:EW-1]));
  assign sat_val = ovf ? {shifted[ACCW-1], {(EW-1){!shifted[ACCW-1]}}}
                       : shifted[EW-1:0];

  // Payload registers
  always_ff @(posedge clk) begin
    rd_tag  <= issue_tag;
    mul_tag <= rd_tag;
    prod    <= l_op * r_op;
    if (mul_vld) begin
      acc     <= acc_next;
      acc_tag <= mul_tag;
    end
    if (acc_done) begin
      product_index <= acc_tag.index;
      product_value <= 32'(sat_val);
      saturated     <= ovf;
      last          <= acc_tag.last_cell;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      left_vld  <= '0;
      right_vld <= '0;
      busy      <= 1'b0;
      issuing   <= 1'b0;
      row       <= '0;
      col       <= '0;
      k         <= '0;
      rd_vld    <= 1'b0;
      mul_vld   <= 1'b0;
      acc_done  <= 1'b0;
      valid     <= 1'b0;
    end else begin
      if (wr_left) begin
        left_vld[wr_addr] <= 1'b1;
      end
      if (wr_right) begin
        right_vld[wr_addr] <= 1'b1;
      end

      if (accept && (opcode == mm4_pkg::OP_COMPUTE)) begin
        busy    <= 1'b1;
        issuing <= 1'b1;
        row     <= '0;
        col     <= '0;
        k       <= '0;
      end else if (issuing) begin
        // advance k, then col, then row
        if (k == KLAST) begin
          k <= '0;
          if (col == KLAST) begin
            col <= '0;
            if (row == KLAST) begin
              issuing <= 1'b0;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            col <= col + 1'b1;
          end
        end else begin
          k <= k + 1'b1;
        end
      end

      rd_vld   <= issuing;
      mul_vld  <= rd_vld;
      acc_done <= mul_vld && mul_tag.last_k;
      valid    <= acc_done;

      // drop busy once the final element has been shown
      if (valid && last) begin
        busy <= 1'b0;
      end
    end
  end

  a_valid_in_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> busy) else $error("result shown while idle");

  a_issue_in_busy: assert property (@(posedge clk) disable iff (rst)
    issuing |-> busy) else $error("reads issued while idle");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == mm4_pkg::OP_COMPUTE) |=> (busy && issuing))
    else $error("compute item did not start the sequencer");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |-> (product_index == 4'(NCELLS - 1)))
    else $error("last flag on wrong element");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(wr_left || wr_right)) else $error("store written during compute");

endmodule

// ----- sim/matrix4x4_multiply_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for matrix4x4_multiply_top: loads both stores, runs
// products and compares each streamed element with a Q16.16 predictor.
// Depends on mm4_pkg for the opcode constants.
module matrix4x4_multiply_top_tb;

  localparam int DIM            = 4;
  localparam int FRAC_BITS      = 16;
  localparam int CELLS          = DIM * DIM;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 160;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = DIM * DIM * DIM + 8;

  localparam logic signed [65:0] ELEM_MAX = 66'sd2147483647;
  localparam logic signed [65:0] ELEM_MIN = -66'sd2147483648;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] value;
    logic        clipped;
    logic        last;
  } product_t;

  class matmul_scoreboard;
    logic signed [31:0] left_store [CELLS];
    logic signed [31:0] right_store [CELLS];
    product_t pending_products [$];
    int mismatches;
    int loads_seen;
    int products_seen;
    int ignored_seen;
    int elements_checked;
    int clipped_seen;

    function new();
      foreach (left_store[i]) begin
        left_store[i]  = '0;
        right_store[i] = '0;
      end
      mismatches       = 0;
      loads_seen       = 0;
      products_seen    = 0;
      ignored_seen     = 0;
      elements_checked = 0;
      clipped_seen     = 0;
    endfunction

    // Full-width sum of DIM terms, arithmetic shift, clip to 32 bits.
    function void predict_products();
      logic signed [65:0] acc;
      logic signed [65:0] scaled;
      product_t p;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          acc = '0;
          for (int k = 0; k < DIM; k++) begin
            acc = acc + left_store[r * DIM + k] * right_store[k * DIM + c];
          end
          scaled = acc >>> FRAC_BITS;
          if (scaled > ELEM_MAX) begin
            p.value   = 32'h7FFF_FFFF;
            p.clipped = 1'b1;
          end else if (scaled < ELEM_MIN) begin
            p.value   = 32'h8000_0000;
            p.clipped = 1'b1;
          end else begin
            p.value   = scaled[31:0];
            p.clipped = 1'b0;
          end
          p.index = 4'(r * DIM + c);
          p.last  = (r == DIM - 1) && (c == DIM - 1);
          pending_products.push_back(p);
        end
      end
    endfunction

    function void note_item(logic [1:0] op, logic [3:0] idx, logic [31:0] val);
      case (op)
        mm4_pkg::OP_LOAD_LEFT: begin
          if (idx < CELLS) left_store[idx] = val;
          loads_seen++;
        end
        mm4_pkg::OP_LOAD_RIGHT: begin
          if (idx < CELLS) right_store[idx] = val;
          loads_seen++;
        end
        mm4_pkg::OP_COMPUTE: begin
          predict_products();
          products_seen++;
        end
        default: ignored_seen++;
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [3:0] idx, logic [31:0] val, logic sat, logic lst);
      product_t want;
      if (pending_products.size() == 0) begin
        report_mismatch("element with nothing pending (index)", 32'(idx), '0);
        return;
      end
      want = pending_products.pop_front();
      elements_checked++;
      if (want.clipped) clipped_seen++;
      if (idx !== want.index) report_mismatch("product_index", 32'(idx), 32'(want.index));
      if (val !== want.value) report_mismatch("product_value", val, want.value);
      if (sat !== want.clipped) report_mismatch("saturated", 32'(sat), 32'(want.clipped));
      if (lst !== want.last) report_mismatch("last", 32'(lst), 32'(want.last));
    endtask

    function int outstanding();
      return pending_products.size();
    endfunction
  endclass

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic [1:0]  opcode        = mm4_pkg::OP_LOAD_LEFT;
  logic [3:0]  element_index = '0;
  logic [31:0] element_value = '0;
  logic        busy;
  logic        valid;
  logic [3:0]  product_index;
  logic [31:0] product_value;
  logic        saturated;
  logic        last;

  matmul_scoreboard sb;
  int idle_cycles = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  bit steady      = 1'b0;

  matrix4x4_multiply_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .element_index (element_index),
    .element_value (element_value),
    .valid         (valid),
    .product_index (product_index),
    .product_value (product_value),
    .saturated     (saturated),
    .last          (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sample at the edge that accepts; the driver's updates land after it.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_item(opcode, element_index, element_value);
      if (valid) sb.check_result(product_index, product_value, saturated, last);
    end
    if ((start && !busy) || valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no item or element moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Called just after a rising edge; returns at the edge that takes the item, or after a random idle gap.
  task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                           input logic [31:0] val);
    int gap;
    start         <= 1'b1;
    opcode        <= op;
    element_index <= idx;
    element_value <= val;
    do @(posedge clk); while (busy);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 10);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        // Drop start and scramble the fields while idle.
        start         <= 1'b0;
        opcode        <= 2'($urandom);
        element_index <= 4'($urandom);
        element_value <= $urandom;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [31:0] rand_element();
    logic [31:0] v;
    v = $urandom >> $urandom_range(0, 31);
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      3:       return $urandom_range(0, 1) ? -v : v;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    logic [1:0] op;
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: product of cleared stores, clipping both ways, exact limits.
    send_item(mm4_pkg::OP_COMPUTE,    4'd0,  32'h0000_0000);
    send_item(mm4_pkg::OP_LOAD_LEFT,  4'd0,  32'h7FFF_FFFF);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd0,  32'h7FFF_FFFF);
    send_item(mm4_pkg::OP_LOAD_LEFT,  4'd5,  32'h8000_0000);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd4,  32'h7FFF_FFFF);
    send_item(mm4_pkg::OP_LOAD_LEFT,  4'd15, 32'h8000_0000);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd15, 32'h8000_0000);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd1,  32'h0001_0000);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd6,  32'hFFFF_0000);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd5,  32'h0001_0000);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd2,  32'hFFFF_0000);
    send_item(OP_UNUSED,              4'd15, 32'hFFFF_FFFF);
    send_item(mm4_pkg::OP_COMPUTE,    4'd15, 32'hFFFF_FFFF);
    send_item(mm4_pkg::OP_LOAD_LEFT,  4'd10, 32'hFFFF_FFFF);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd10, 32'h0000_0001);
    send_item(mm4_pkg::OP_LOAD_LEFT,  4'd11, 32'h0001_8000);
    send_item(mm4_pkg::OP_LOAD_RIGHT, 4'd14, 32'h0002_0000);
    send_item(mm4_pkg::OP_COMPUTE,    4'd0,  32'h0000_0000);

    // Random: bursts of loads closed by a product, some full refills.
    n = items_sent + RANDOM_ITEMS;
    while (items_sent < n) begin
      steady = (items_sent > n - RANDOM_ITEMS / 2) && (items_sent < n - RANDOM_ITEMS / 4);
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < 2 * CELLS; i++) begin
          send_item(i < CELLS ? mm4_pkg::OP_LOAD_LEFT : mm4_pkg::OP_LOAD_RIGHT,
                    4'(i % CELLS),
                    $urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 19))
            0:       op = OP_UNUSED;
            1:       op = mm4_pkg::OP_COMPUTE;
            default: op = $urandom_range(0, 1) ? mm4_pkg::OP_LOAD_LEFT
                                               : mm4_pkg::OP_LOAD_RIGHT;
          endcase
          send_item(op, 4'($urandom_range(0, 15)), rand_element());
        end
      end
      send_item(mm4_pkg::OP_COMPUTE, 4'($urandom), $urandom);
    end
    start <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run took %0d items: %0d loads, %0d products, %0d dropped opcodes.",
             items_sent, sb.loads_seen, sb.products_seen, sb.ignored_seen);
    $display("Checked %0d product elements, %0d of them clipped; %0d mismatches.",
             sb.elements_checked, sb.clipped_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
